/* sv/volume_gradient_magnitude_macros.svh */
// Assertion macros for the gradient block.
`ifndef VOLUME_GRADIENT_MAGNITUDE_MACROS_SVH
`define VOLUME_GRADIENT_MAGNITUDE_MACROS_SVH
// Implication checked on every edge outside reset.
`define VGM_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("violation");
// Next-cycle implication.
`define VGM_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("violation");
`endif

/* sv/vgm_pkg.sv */
`timescale 1ns / 1ps
package vgm_pkg;
  localparam int SAMPLE_W = 16;
  localparam int MAG_W = 18;
  localparam int REG_W = 9;
  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PLANES = 2'd2;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN = 1'b1;
  typedef struct packed {
    logic op;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;
  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic final_res;
  } out_item_t;
endpackage

/* sv/vgm_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, at most two result bits per stage.
module vgm_sqrt
  import vgm_pkg::*;
#(
  parameter int IN_W = 38,
  parameter int TAG_W = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [IN_W-1:0] radicand,
  input  logic [TAG_W-1:0] in_tag,
  output logic out_valid,
  output logic [MAG_W-1:0] root,
  output logic [TAG_W-1:0] out_tag
);
  localparam int RW = MAG_W + 1;
  localparam int NB = RW;
  localparam int NS = (NB + 1) / 2;
  localparam int VW = 2 * RW + 2;
  logic [VW-1:0] rem [NS+1];
  logic [RW-1:0] res [NS+1];
  logic [TAG_W-1:0] tag [NS+1];
  logic vld [NS+1];
  logic [RW:0] mx;
  always_comb begin
    rem[0] = VW'(radicand);
    res[0] = '0;
    tag[0] = in_tag;
    vld[0] = in_valid;
  end
  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [VW-1:0] rem_q;
    logic [RW-1:0] res_q;
    logic [TAG_W-1:0] tag_q;
    logic vld_q;
    logic [VW-1:0] r2, t2;
    logic [RW-1:0] q2;
    always_comb begin
      r2 = rem[s];
      q2 = res[s];
      for (int k = 0; k < 2; k++) begin
        t2 = VW'({q2, 2'b01}) << (2 * (NB - 1 - (2 * s + k)));
        if (2 * s + k < NB && r2 >= t2) begin
          r2 = r2 - t2;
          q2 = {q2[RW-2:0], 1'b1};
        end else if (2 * s + k < NB) begin
          q2 = {q2[RW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld[s];
      end
      if (en) begin
        rem_q <= r2;
        res_q <= q2;
        tag_q <= tag[s];
      end
    end
    assign rem[s+1] = rem_q;
    assign res[s+1] = res_q;
    assign tag[s+1] = tag_q;
    assign vld[s+1] = vld_q;
  end
  assign mx = {1'b0, res[NS]};
  assign root = (mx > (RW+1)'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : res[NS][MAG_W-1:0];
  assign out_valid = vld[NS];
  assign out_tag = tag[NS];
endmodule

/* sv/volume_gradient_magnitude.sv */
`timescale 1ns / 1ps
// A result is registered through stages 1 to 5, then the square-root stages.
// One request per cycle when not stalled; stall freezes the whole pipeline.
// A register write holds the input while the extent products settle.
// Reset: synchronous active high; counters clear, registers take 256/256/1.
// The voxel store needs no clearing pass: only written entries are used.
module volume_gradient_magnitude
  import vgm_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_PLANES = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);
`include "volume_gradient_magnitude_macros.svh"
  localparam int SAMPLE_BITS = SAMPLE_W;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int ZW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT + 1;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(longint'(MAX_WIDTH) * MAX_HEIGHT * MAX_PLANES + 1);
  localparam int DW = SAMPLE_BITS + 2;
  localparam int SW = 2 * DW + 2;
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_PLANES + 1);

  // Configuration registers and their effective (clamped) extents.
  logic [REG_W-1:0] width, height, planes;
  logic [EW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [PW-1:0] d_eff;
  logic [CW-1:0] total, lag, plane_sz;
  logic [1:0] cfg_hold;
  always_ff @(posedge clk) begin
    if (rst) begin
      width <= REG_W'(256);
      height <= REG_W'(256);
      planes <= REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width <= cfg_data;
        REG_HEIGHT: height <= cfg_data;
        REG_PLANES: planes <= cfg_data;
        default: ;
      endcase
    end
  end
  always_comb begin
    w_eff = (width == 0) ? EW'(1) : (32'(width) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(width);
    h_eff = (height == 0) ? HW'(1) : (32'(height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height);
    d_eff = (planes == 0) ? PW'(1) : (32'(planes) > MAX_PLANES) ? PW'(MAX_PLANES) : PW'(planes);
  end
  // Extents are to change only while idle, which the block does not enforce;
  // the products are registered, and the input is held while they settle.
  always_ff @(posedge clk) begin
    plane_sz <= CW'(w_eff) * CW'(h_eff);
    total <= plane_sz * CW'(d_eff);
    lag <= (d_eff > 1) ? plane_sz : CW'(w_eff);
  end
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      cfg_hold <= 2'd2;
    end else if (cfg_hold != 2'd0) begin
      cfg_hold <= cfg_hold - 2'd1;
    end
  end

  // Pipeline enable: everything advances unless the output is held.
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en || (cfg_hold != 2'd0);
  logic acc;
  assign acc = in_valid && !in_stall;

  // Input side: write pointer and count.
  logic [CW-1:0] in_cnt;
  logic [AW-1:0] wr_ptr, rd_base;
  logic is_smp, emit;
  assign is_smp = (in_data.op == OP_SAMPLE) && (in_cnt < total);
  assign emit = acc && (is_smp ? (in_cnt + 1'b1 > lag) : (in_cnt >= total));

  // Output coordinates of the next result.
  logic [XW:0] ox;
  logic [YW:0] oy;
  logic [ZW:0] oz;
  logic [CW-1:0] op_idx;
  logic last;
  assign last = (op_idx == total - 1'b1);
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      in_cnt <= '0;
      wr_ptr <= '0;
      rd_base <= '0;
      ox <= '0;
      oy <= '0;
      oz <= '0;
      op_idx <= '0;
    end else if (acc) begin
      if (is_smp) begin
        in_cnt <= in_cnt + 1'b1;
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_cnt <= '0;
          wr_ptr <= '0;
          rd_base <= '0;
          ox <= '0;
          oy <= '0;
          oz <= '0;
          op_idx <= '0;
        end else begin
          op_idx <= op_idx + 1'b1;
          rd_base <= (rd_base == AW'(DEPTH - 1)) ? '0 : rd_base + 1'b1;
          if (32'(ox) + 1 >= 32'(w_eff)) begin
            ox <= '0;
            if (32'(oy) + 1 >= 32'(h_eff)) begin
              oy <= '0;
              oz <= oz + 1'b1;
            end else begin
              oy <= oy + 1'b1;
            end
          end else begin
            ox <= ox + 1'b1;
          end
        end
      end
    end
  end

  // Stage 1: work out the seven neighbor addresses and each axis mode.
  // Mode per axis: 0 none, 1 low border, 2 high border, 3 interior.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] o);
    logic [AW+1:0] s;
    begin
      s = (AW+2)'(a) + (AW+2)'(o);
      if (s >= (AW+2)'(DEPTH)) s = s - (AW+2)'(DEPTH);
      return s[AW-1:0];
    end
  endfunction
  function automatic logic [AW-1:0] wrap_sub(logic [AW-1:0] a, logic [CW-1:0] o);
    logic [AW+1:0] s;
    begin
      s = (AW+2)'(a) + (AW+2)'(DEPTH) - (AW+2)'(o);
      if (s >= (AW+2)'(DEPTH)) s = s - (AW+2)'(DEPTH);
      return s[AW-1:0];
    end
  endfunction
  function automatic logic [1:0] mode(logic [12:0] c, logic [12:0] n);
    begin
      if (n <= 1) return 2'd0;
      if (c == 0) return 2'd1;
      if (c == n - 1) return 2'd2;
      return 2'd3;
    end
  endfunction

  logic s1_v, s1_last;
  logic [1:0] s1_m [3];
  logic [AW-1:0] s1_a [7];
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= emit;
    end
    if (en) begin
      s1_last <= last;
      s1_m[0] <= mode(13'(ox), 13'(w_eff));
      s1_m[1] <= mode(13'(oy), 13'(h_eff));
      s1_m[2] <= mode(13'(oz), 13'(d_eff));
      s1_a[0] <= rd_base;
      s1_a[1] <= wrap_add(rd_base, CW'(1));
      s1_a[2] <= wrap_sub(rd_base, CW'(1));
      s1_a[3] <= wrap_add(rd_base, CW'(w_eff));
      s1_a[4] <= wrap_sub(rd_base, CW'(w_eff));
      s1_a[5] <= wrap_add(rd_base, plane_sz);
      s1_a[6] <= wrap_sub(rd_base, plane_sz);
    end
  end

  // Voxel store, kept as four identical copies so that each copy is read at
  // no more than two addresses a cycle: the center voxel, the x pair, the
  // y pair and the z pair. The write of the current request lands before
  // any read that needs it.
  logic [SAMPLE_BITS-1:0] mem_c [DEPTH];
  logic [SAMPLE_BITS-1:0] mem_x [DEPTH];
  logic [SAMPLE_BITS-1:0] mem_y [DEPTH];
  logic [SAMPLE_BITS-1:0] mem_z [DEPTH];
  logic [SAMPLE_BITS-1:0] rd [7];
  always_ff @(posedge clk) begin
    if (acc && is_smp) begin
      mem_c[wr_ptr] <= in_data.sample[SAMPLE_BITS-1:0];
      mem_x[wr_ptr] <= in_data.sample[SAMPLE_BITS-1:0];
      mem_y[wr_ptr] <= in_data.sample[SAMPLE_BITS-1:0];
      mem_z[wr_ptr] <= in_data.sample[SAMPLE_BITS-1:0];
    end
  end
  logic s2_v, s2_last;
  logic [1:0] s2_m [3];
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_last <= s1_last;
      s2_m <= s1_m;
      rd[0] <= mem_c[s1_a[0]];
      rd[1] <= mem_x[s1_a[1]];
      rd[2] <= mem_x[s1_a[2]];
      rd[3] <= mem_y[s1_a[3]];
      rd[4] <= mem_y[s1_a[4]];
      rd[5] <= mem_z[s1_a[5]];
      rd[6] <= mem_z[s1_a[6]];
    end
  end

  // Stage 3: absolute axis differences, one-sided and doubled at a border.
  function automatic logic [DW-1:0] diff(logic [1:0] m, logic [SAMPLE_BITS-1:0] c,
                                        logic [SAMPLE_BITS-1:0] p,
                                        logic [SAMPLE_BITS-1:0] n);
    logic signed [DW:0] d;
    begin
      unique case (m)
        2'd1: d = ((DW+1)'(p) - (DW+1)'(c)) <<< 1;
        2'd2: d = ((DW+1)'(c) - (DW+1)'(n)) <<< 1;
        2'd3: d = (DW+1)'(p) - (DW+1)'(n);
        default: d = '0;
      endcase
      if (d < 0) d = -d;
      return d[DW-1:0];
    end
  endfunction
  logic s3_v, s3_last, s3_zero;
  logic [DW-1:0] s3_d [3];
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_last <= s2_last;
      s3_zero <= (rd[0] == '0);
      s3_d[0] <= diff(s2_m[0], rd[0], rd[1], rd[2]);
      s3_d[1] <= diff(s2_m[1], rd[0], rd[3], rd[4]);
      s3_d[2] <= diff(s2_m[2], rd[0], rd[5], rd[6]);
    end
  end

  // Stage 4: squares; stage 5: sum.
  logic s4_v, s4_last, s4_zero;
  logic [2*DW-1:0] s4_q [3];
  logic s5_v;
  logic [SW-1:0] s5_s;
  logic [1:0] s5_tag;
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
    if (en) begin
      s4_last <= s3_last;
      s4_zero <= s3_zero;
      for (int i = 0; i < 3; i++) s4_q[i] <= s3_d[i] * s3_d[i];
      s5_s <= s4_zero ? '0 : SW'(s4_q[0]) + SW'(s4_q[1]) + SW'(s4_q[2]);
      s5_tag <= {s4_last, 1'b0};
    end
  end

  logic [MAG_W-1:0] root;
  logic [1:0] rt_tag;
  logic rt_v;
  vgm_sqrt #(.IN_W(SW), .TAG_W(2)) u_sqrt (
    .clk(clk), .rst(rst || cfg_we), .en(en), .in_valid(s5_v), .radicand(s5_s),
    .in_tag(s5_tag), .out_valid(rt_v), .root(root), .out_tag(rt_tag)
  );
  assign out_valid = rt_v;
  assign out_data.magnitude = root;
  assign out_data.final_res = rt_tag[1];

  `VGM_ASSERT_IMP(a_stall_freeze, out_valid && out_stall, in_stall)
  `VGM_ASSERT_NXT(a_cfg_flush, cfg_we, !s1_v && !s2_v)
  `VGM_ASSERT_NXT(a_last_restart, acc && emit && last, in_cnt == '0 && op_idx == '0)
endmodule
